FILE: rtl/core/assert_macros.svh
// assertion helpers, included by the top-level display module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: rtl/core/twd_pkg.sv
`default_nettype none

package twd_pkg;

  localparam int DEF_RING_DEPTH     = 4096;
  localparam int DEF_SCREEN_COLUMNS = 320;
  localparam int DEF_SEARCH_SPAN    = 1000;

  localparam int SAMPLE_W = 16;
  localparam int CFG_AW   = 5;
  localparam int REG_IW   = CFG_AW - 2;

  // distances of the trigger taps from the candidate position
  localparam int TAP_B    = 4;
  localparam int TAP_C    = 5;
  localparam int TAP_SPAN = 9;

  localparam logic signed [SAMPLE_W:0] SCORE_FLOOR = {1'b1, {SAMPLE_W{1'b0}}};

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_FRAME  = 2'd1;
  localparam logic [1:0] OP_COLUMN = 2'd2;

  localparam logic [REG_IW-1:0] REG_TRIGGER_ENABLE = REG_IW'(0);
  localparam logic [REG_IW-1:0] REG_TRIGGER_DELAY  = REG_IW'(1);
  localparam logic [REG_IW-1:0] REG_AMP_SCALE      = REG_IW'(2);
  localparam logic [REG_IW-1:0] REG_OUT_CENTER     = REG_IW'(3);
  localparam logic [REG_IW-1:0] REG_IN_CENTER      = REG_IW'(4);

  localparam logic [11:0] RST_TRIGGER_DELAY = 12'd1120;
  localparam logic [7:0]  RST_AMP_SCALE     = 8'd54;
  localparam logic [7:0]  RST_OUT_CENTER    = 8'd60;
  localparam logic [7:0]  RST_IN_CENTER     = 8'd180;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic                       panel_select;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [8:0] column_x;
    logic [7:0] bar_top;
    logic [7:0] bar_height;
    logic       result_panel;
    logic       last_column;
  } bar_t;

endpackage

`default_nettype wire

FILE: rtl/core/twd_ring.sv
`default_nettype none

module twd_ring
  import twd_pkg::*;
#(
  parameter int DEPTH = DEF_RING_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read: rd_data is loaded in the cycle after rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/triggered_waveform_display.sv
// triggered two-panel waveform display
// cmd channel (valid/ready, cmd_t) carries three kinds of transaction:
//   write  - stores a sample in the chosen panel's ring; writes go
//            back to back while cmd_ready is high
//   frame  - sets the panel's start position; with the trigger on it walks
//            SEARCH_SPAN + 9 ring entries one read per cycle, and the next
//            transaction is taken only once the walk is done
//   column - reads one sample, scales it and returns one bar on the bar
//            channel; the ring read, the product register and the output
//            register lie in order between the transaction and the bar,
//            and no further transaction is taken until the bar is loaded
// each ring is one synchronous memory with one read port and one write port
// bar holds in an output register; a stalled receiver holds it there, writes
// and frame starts still go through, but a further column waits in its last
// step with cmd_ready low until the register frees up
// after reset both rings are zeroed by a pass over all RING_DEPTH entries,
// during which cmd_ready stays low; the apb port works throughout
// apb registers sit at 4*index, pready is tied high
`default_nettype none
`include "assert_macros.svh"

module triggered_waveform_display
  import twd_pkg::*;
#(
  parameter int RING_DEPTH     = DEF_RING_DEPTH,
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SEARCH_SPAN    = DEF_SEARCH_SPAN
) (
  input  logic              clk,
  input  logic              rst,
  // sample, frame and column transactions
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  // bar results
  output logic              bar_valid,
  input  logic              bar_ready,
  output bar_t              bar,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CW    = $clog2(SCREEN_COLUMNS);
  localparam int NSTEP = SEARCH_SPAN + TAP_SPAN;
  localparam int SW    = $clog2(NSTEP + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(SCREEN_COLUMNS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_SEARCH  = 5'b00100,
    ST_COL_MUL = 5'b01000,
    ST_COL_OUT = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_ADDR : p - AW'(1);
  endfunction

  state_t state;

  // configuration registers
  logic        trigger_enable;
  logic [11:0] trigger_delay;
  logic [7:0]  amplitude_scale;
  logic [7:0]  output_center_row;
  logic [7:0]  input_center_row;

  // per-panel pointers and column counters
  logic [AW-1:0] wp_in, wp_out, rp_in, rp_out;
  logic [CW-1:0] cc_in, cc_out;

  // clearing pass
  logic [AW-1:0] clr_addr;

  // trigger search
  logic                       cur_sel;
  logic [AW-1:0]              srch_addr;
  logic [AW-1:0]              rv_addr;
  logic                       rv;
  logic [SW-1:0]              iss;
  logic [SW-1:0]              ret;
  logic signed [SAMPLE_W:0]   best_score;
  logic [AW-1:0]              best_pos;
  logic signed [SAMPLE_W-1:0] win [TAP_SPAN];

  // column datapath
  logic signed [SAMPLE_W+8:0] prod;

  // ring ports
  logic                       ring_rd_en;
  logic [AW-1:0]              ring_rd_addr;
  logic                       in_wr_en, out_wr_en;
  logic [AW-1:0]              ring_wr_addr;
  logic signed [SAMPLE_W-1:0] ring_wr_data;
  logic signed [SAMPLE_W-1:0] in_rd_data, out_rd_data;
  logic signed [SAMPLE_W-1:0] rd_sample;

  logic cmd_fire, is_write, is_frame, is_column, cfg_write;
  logic [AW-1:0] wp_sel, rp_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid & cmd_ready;
  assign is_write  = cmd_fire && (cmd.opcode == OP_WRITE);
  assign is_frame  = cmd_fire && (cmd.opcode == OP_FRAME);
  assign is_column = cmd_fire && (cmd.opcode == OP_COLUMN);
  assign wp_sel    = cmd.panel_select ? wp_in : wp_out;
  assign rp_sel    = cmd.panel_select ? rp_in : rp_out;
  assign rd_sample = cur_sel ? in_rd_data : out_rd_data;

  // register readback
  always_comb begin
    prdata = '0;
    case (paddr[CFG_AW-1:2])
      REG_TRIGGER_ENABLE: prdata = 32'(trigger_enable);
      REG_TRIGGER_DELAY:  prdata = 32'(trigger_delay);
      REG_AMP_SCALE:      prdata = 32'(amplitude_scale);
      REG_OUT_CENTER:     prdata = 32'(output_center_row);
      REG_IN_CENTER:      prdata = 32'(input_center_row);
      default:            prdata = '0;
    endcase
  end

  // search origin: write pointer minus delay, first read nine entries ahead
  logic [AW:0]   origin_wide, first_wide;
  logic [AW-1:0] origin, first_addr;

  always_comb begin
    if ({1'b0, wp_sel} >= (AW+1)'(trigger_delay)) begin
      origin_wide = {1'b0, wp_sel} - (AW+1)'(trigger_delay);
    end else begin
      origin_wide = {1'b0, wp_sel} + (AW+1)'(RING_DEPTH) - (AW+1)'(trigger_delay);
    end
    origin     = origin_wide[AW-1:0];
    first_wide = {1'b0, origin} + (AW+1)'(TAP_SPAN);
    if (first_wide >= (AW+1)'(RING_DEPTH)) begin
      first_wide = first_wide - (AW+1)'(RING_DEPTH);
    end
    first_addr = first_wide[AW-1:0];
  end

  // ring access: the clearing pass and sample writes share the write port
  logic srch_issue;

  assign srch_issue = (state == ST_SEARCH) && (iss != SW'(NSTEP));

  always_comb begin
    ring_rd_en   = srch_issue;
    ring_rd_addr = srch_addr;
    if (is_column) begin
      ring_rd_en   = 1'b1;
      ring_rd_addr = rp_sel;
    end
  end

  assign ring_wr_addr = (state == ST_CLEAR) ? clr_addr : wp_sel;
  assign ring_wr_data = (state == ST_CLEAR) ? '0 : cmd.sample;
  assign in_wr_en     = (state == ST_CLEAR) | (is_write & cmd.panel_select);
  assign out_wr_en    = (state == ST_CLEAR) | (is_write & ~cmd.panel_select);

  twd_ring #(.DEPTH(RING_DEPTH)) u_in_ring (
    .clk     (clk),
    .wr_en   (in_wr_en),
    .wr_addr (ring_wr_addr),
    .wr_data (ring_wr_data),
    .rd_en   (ring_rd_en),
    .rd_addr (ring_rd_addr),
    .rd_data (in_rd_data)
  );

  twd_ring #(.DEPTH(RING_DEPTH)) u_out_ring (
    .clk     (clk),
    .wr_en   (out_wr_en),
    .wr_addr (ring_wr_addr),
    .wr_data (ring_wr_data),
    .rd_en   (ring_rd_en),
    .rd_addr (ring_rd_addr),
    .rd_data (out_rd_data)
  );

  // trigger scoring: newest read is the candidate, older taps sit in the window
  logic signed [SAMPLE_W:0] score;
  logic                     hit;
  logic                     search_done;
  logic [AW-1:0]            best_pos_now;

  always_comb begin
    score = (SAMPLE_W+1)'(rd_sample) - (SAMPLE_W+1)'(win[TAP_SPAN-1]);
    hit   = rv && (ret >= SW'(TAP_SPAN))
            && (win[TAP_B-1][SAMPLE_W-1] != win[TAP_C-1][SAMPLE_W-1])
            && (score > best_score);
    best_pos_now = hit ? rv_addr : best_pos;
    search_done  = rv && (ret == SW'(NSTEP - 1));
  end

  // bar geometry from the registered product
  logic [9:0]    y_bits;
  logic [9:0]    mag;
  logic [7:0]    center;
  logic [CW-1:0] cc_cur;
  logic [AW-1:0] rp_cur;
  logic [CW-1:0] cc_inc;
  logic          out_load;
  bar_t          bar_next;

  always_comb begin
    y_bits = prod[SAMPLE_W+8:15];
    mag    = ~y_bits + 10'd1;
    center = cur_sel ? input_center_row : output_center_row;
    cc_cur = cur_sel ? cc_in : cc_out;
    rp_cur = cur_sel ? rp_in : rp_out;
    cc_inc = (cc_cur == LAST_COL) ? '0 : cc_cur + CW'(1);

    bar_next.column_x     = 9'(cc_cur);
    bar_next.result_panel = cur_sel;
    bar_next.last_column  = (cc_cur == LAST_COL);
    if (y_bits[9]) begin
      // negative value: bar above the centre line, clipped at the top of the screen
      if (mag > {2'b00, center}) begin
        bar_next.bar_top    = '0;
        bar_next.bar_height = center;
      end else begin
        bar_next.bar_top    = center - mag[7:0];
        bar_next.bar_height = mag[7:0];
      end
    end else begin
      bar_next.bar_top    = center;
      bar_next.bar_height = y_bits[7:0];
    end
    out_load = (state == ST_COL_OUT) && (!bar_valid || bar_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      clr_addr          <= '0;
      wp_in             <= '0;
      wp_out            <= '0;
      rp_in             <= '0;
      rp_out            <= '0;
      cc_in             <= '0;
      cc_out            <= '0;
      bar_valid         <= 1'b0;
      rv                <= 1'b0;
      iss               <= '0;
      ret               <= '0;
      best_score        <= SCORE_FLOOR;
      trigger_enable    <= 1'b0;
      trigger_delay     <= RST_TRIGGER_DELAY;
      amplitude_scale   <= RST_AMP_SCALE;
      output_center_row <= RST_OUT_CENTER;
      input_center_row  <= RST_IN_CENTER;
    end else begin
      if (cfg_write) begin
        case (paddr[CFG_AW-1:2])
          REG_TRIGGER_ENABLE: trigger_enable    <= pwdata[0];
          REG_TRIGGER_DELAY:  trigger_delay     <= pwdata[11:0];
          REG_AMP_SCALE:      amplitude_scale   <= pwdata[7:0];
          REG_OUT_CENTER:     output_center_row <= pwdata[7:0];
          REG_IN_CENTER:      input_center_row  <= pwdata[7:0];
          default: ;
        endcase
      end

      // a new bar takes the register, else a taken bar empties it
      if (out_load) begin
        bar_valid <= 1'b1;
      end else if (bar_valid && bar_ready) begin
        bar_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (is_write) begin
            if (cmd.panel_select) begin
              wp_in <= ptr_inc(wp_in);
            end else begin
              wp_out <= ptr_inc(wp_out);
            end
          end
          if (is_frame) begin
            if (trigger_enable) begin
              cur_sel    <= cmd.panel_select;
              srch_addr  <= first_addr;
              best_pos   <= origin;
              best_score <= SCORE_FLOOR;
              iss        <= '0;
              ret        <= '0;
              rv         <= 1'b0;
              state      <= ST_SEARCH;
            end else if (cmd.panel_select) begin
              rp_in <= '0;
              cc_in <= '0;
            end else begin
              rp_out <= '0;
              cc_out <= '0;
            end
          end
          if (is_column) begin
            cur_sel <= cmd.panel_select;
            state   <= ST_COL_MUL;
          end
        end

        ST_SEARCH: begin
          rv      <= srch_issue;
          rv_addr <= srch_addr;
          if (srch_issue) begin
            srch_addr <= ptr_dec(srch_addr);
            iss       <= iss + SW'(1);
          end
          if (rv) begin
            win[0] <= rd_sample;
            for (int i = 1; i < TAP_SPAN; i++) begin
              win[i] <= win[i-1];
            end
            ret <= ret + SW'(1);
          end
          if (hit) begin
            best_score <= score;
            best_pos   <= rv_addr;
          end
          if (search_done) begin
            if (cur_sel) begin
              rp_in <= best_pos_now;
              cc_in <= '0;
            end else begin
              rp_out <= best_pos_now;
              cc_out <= '0;
            end
            state <= ST_IDLE;
          end
        end

        ST_COL_MUL: begin
          prod  <= rd_sample * $signed({1'b0, amplitude_scale});
          state <= ST_COL_OUT;
        end

        ST_COL_OUT: begin
          if (out_load) begin
            bar <= bar_next;
            if (cur_sel) begin
              rp_in <= ptr_inc(rp_cur);
              cc_in <= cc_inc;
            end else begin
              rp_out <= ptr_inc(rp_cur);
              cc_out <= cc_inc;
            end
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // no ring write may land while a search walks the ring
  `ASSERT_NEVER(a_no_write_in_search, clk, rst, (state == ST_SEARCH) && (in_wr_en || out_wr_en), "ring written during trigger search")
  // read and write never meet on one entry in the same cycle
  `ASSERT_NEVER(a_no_rw_overlap, clk, rst, ring_rd_en && (in_wr_en || out_wr_en) && (ring_rd_addr == ring_wr_addr), "ring read and write collide")
  // returned reads never outrun issued reads
  `ASSERT_CLK(a_ret_le_iss, clk, rst, (state == ST_SEARCH) |-> (ret <= iss), "search returned more reads than issued")
  // untriggered frame start rewinds the input panel
  `ASSERT_CLK(a_frame_rewind, clk, rst, (is_frame && !trigger_enable && cmd.panel_select) |=> (rp_in == '0 && cc_in == '0), "frame start did not rewind input panel")

endmodule

`default_nettype wire
